// ===== rtl/nearest_waypoint_search_top_defines.svh =====
// Assertion macros shared by the nearest waypoint search RTL
`ifndef NEAREST_WAYPOINT_SEARCH_TOP_DEFINES_SVH
`define NEAREST_WAYPOINT_SEARCH_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock edge outside reset
`define NWS_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising clock edge outside reset
`define NWS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/nws_pkg.sv =====
package nws_pkg;

   // configuration register indexes
   localparam int unsigned CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POSE_X        = 3'd0,
      CSR_POSE_Y        = 3'd1,
      CSR_POSE_HEADING  = 3'd2,
      CSR_DIST_LIMIT    = 3'd3,
      CSR_HEADING_LIMIT = 3'd4
   } nws_csr_idx_type;

   // field widths
   localparam int unsigned COORD_W   = 32;
   localparam int unsigned ANGLE_W   = 16;
   localparam int unsigned LIMIT_W   = 31;
   localparam int unsigned DIST_W    = 64;
   localparam int unsigned INDEX_W   = 12;

   // reset values of the gates; the squared limit follows the distance limit
   localparam logic [LIMIT_W-1:0] DIST_LIMIT_RESET    = 31'h7FFF_FFFF;
   localparam logic [ANGLE_W-1:0] HEADING_LIMIT_RESET = 16'h8000;
   localparam logic [DIST_W-1:0]  LIM_SQ_RESET        = 64'h3FFF_FFFF_0000_0001;

   // per-waypoint flags that travel with the squared distance
   typedef struct packed {
      logic last;   // final waypoint of the query
      logic qual;   // inside capacity and both gates
      logic over;   // waypoint lies past capacity
   } nws_cand_type;

endpackage

// ===== rtl/nws_tracker.sv =====
module nws_tracker #(
   parameter int unsigned IDX_W = 12
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  nws_pkg::nws_cand_type         in_cand,
   input  logic [nws_pkg::DIST_W-1:0]    in_dist,
   input  logic [IDX_W-1:0]              in_pos,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_found,
   output logic [nws_pkg::INDEX_W-1:0]   rsp_best_index,
   output logic                          rsp_overflow
);

   logic [nws_pkg::DIST_W-1:0]  best_dist_sq_ff;
   logic [IDX_W-1:0]            best_pos_ff;
   logic                        any_found_ff;
   logic                        rsp_valid_ff;
   logic                        rsp_found_ff;
   logic [nws_pkg::INDEX_W-1:0] rsp_best_index_ff;
   logic                        rsp_overflow_ff;

   logic                        fire;
   logic                        better;
   logic                        any_found_in;
   logic [IDX_W-1:0]            best_pos_in;
   logic [IDX_W+nws_pkg::INDEX_W-1:0] pos_ext;

   // a closing waypoint waits only while an unread result sits in the output register
   assign in_ready = !in_cand.last || !rsp_valid_ff || rsp_ready;
   assign fire     = in_valid && in_ready;

   // earliest smallest distance wins: replace only on a strict improvement
   assign better       = in_cand.qual && (!any_found_ff || (in_dist < best_dist_sq_ff));
   assign any_found_in = any_found_ff || in_cand.qual;
   assign best_pos_in  = better ? in_pos : best_pos_ff;
   assign pos_ext      = {{nws_pkg::INDEX_W{1'b0}}, best_pos_in};

   // update running minimum; report and clear on the closing waypoint
   always_ff @(posedge clock) begin
      if (reset) begin
         best_dist_sq_ff <= '1;
         best_pos_ff     <= '0;
         any_found_ff    <= 1'b0;
      end else if (fire) begin
         if (in_cand.last) begin
            best_dist_sq_ff <= '1;
            best_pos_ff     <= '0;
            any_found_ff    <= 1'b0;
         end else if (better) begin
            best_dist_sq_ff <= in_dist;
            best_pos_ff     <= in_pos;
            any_found_ff    <= 1'b1;
         end
      end
   end

   // hold the result until the transaction completes
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire && in_cand.last) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && in_cand.last) begin
         rsp_found_ff      <= any_found_in;
         rsp_best_index_ff <= any_found_in ? pos_ext[nws_pkg::INDEX_W-1:0] : '0;
         rsp_overflow_ff   <= in_cand.over;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_found      = rsp_found_ff;
   assign rsp_best_index = rsp_best_index_ff;
   assign rsp_overflow   = rsp_overflow_ff;

`include "nearest_waypoint_search_top_defines.svh"

   `NWS_ASSERT_NEXT(a_clear_after_report, fire && in_cand.last, !any_found_ff && (best_dist_sq_ff == '1), "query state not cleared after report")
   `NWS_ASSERT_IMP(a_pos_zero_when_none, !any_found_ff, best_pos_ff == '0, "best position set with nothing found")
   `NWS_ASSERT_IMP(a_index_zero_when_none, rsp_valid_ff && !rsp_found_ff, rsp_best_index_ff == '0, "index nonzero with nothing found")
   `NWS_ASSERT_NEXT(a_result_held, rsp_valid_ff && !rsp_ready, rsp_valid_ff && $stable(rsp_best_index_ff), "pending result dropped or changed")

endmodule

// ===== rtl/nearest_waypoint_search_top.sv =====
// From acceptance to result valid: abs diff, square, sum, track registers, in order.
// Throughput: one waypoint per cycle; a closing waypoint stalls only while the
// previous result is still unread in the output register.
// Reset (synchronous, active high) restores pose 0, heading 0, full distance and
// heading gates, clears the waypoint count, running minimum and all stage valids.
module nearest_waypoint_search_top #(
   parameter int unsigned MAX_POINTS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic signed [nws_pkg::COORD_W-1:0] req_wp_x,
   input  logic signed [nws_pkg::COORD_W-1:0] req_wp_y,
   input  logic [nws_pkg::ANGLE_W-1:0]       req_wp_heading,
   input  logic                              req_last_point,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_found,
   output logic [nws_pkg::INDEX_W-1:0]       rsp_best_index,
   output logic                              rsp_overflow,
   input  logic                              csr_wr_en,
   input  logic [nws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [nws_pkg::COORD_W-1:0]       csr_wdata
);

   localparam int unsigned IDX_W = $clog2(MAX_POINTS);
   localparam int unsigned CNT_W = $clog2(MAX_POINTS + 2);
   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);

   // configuration registers
   logic [nws_pkg::COORD_W-1:0] pose_x_ff;
   logic [nws_pkg::COORD_W-1:0] pose_y_ff;
   logic [nws_pkg::ANGLE_W-1:0] pose_heading_ff;
   logic [nws_pkg::ANGLE_W-1:0] heading_limit_ff;
   logic [nws_pkg::DIST_W-1:0]  lim_sq_ff;
   logic [nws_pkg::LIMIT_W-1:0] dist_limit_in;
   logic [2*nws_pkg::LIMIT_W-1:0] lim_prod;

   // waypoint counter
   logic [CNT_W-1:0] count_ff;
   logic             accept;
   logic             in_range;

   // stage 1: magnitudes of the offsets
   logic                        v1_ff;
   logic [nws_pkg::COORD_W-1:0] adx_ff;
   logic [nws_pkg::COORD_W-1:0] ady_ff;
   logic                        hd_ok_ff;
   logic                        rng1_ff;
   logic                        last1_ff;
   logic [IDX_W-1:0]            pos1_ff;

   // stage 2: squares
   logic                        v2_ff;
   logic [nws_pkg::DIST_W-1:0]  sx_ff;
   logic [nws_pkg::DIST_W-1:0]  sy_ff;
   logic                        ok2_ff;
   logic                        rng2_ff;
   logic                        last2_ff;
   logic [IDX_W-1:0]            pos2_ff;

   // stage 3: saturated squared distance and gate result
   logic                        v3_ff;
   logic [nws_pkg::DIST_W-1:0]  ds_ff;
   nws_pkg::nws_cand_type       cand3_ff;
   logic [IDX_W-1:0]            pos3_ff;

   logic rdy1, rdy2, rdy3, trk_ready;

   logic signed [nws_pkg::COORD_W:0] dx;
   logic signed [nws_pkg::COORD_W:0] dy;
   logic [nws_pkg::COORD_W:0]        ndx;
   logic [nws_pkg::COORD_W:0]        ndy;
   logic [nws_pkg::ANGLE_W-1:0]      hdiff;
   logic [nws_pkg::ANGLE_W:0]        hmag;
   logic                             hd_ok;
   logic [nws_pkg::DIST_W:0]         dsum;
   logic [nws_pkg::DIST_W-1:0]       ds;

   // write configuration; square the distance limit on its way in
   assign dist_limit_in = csr_wdata[nws_pkg::LIMIT_W-1:0];
   assign lim_prod      = (2*nws_pkg::LIMIT_W)'(dist_limit_in)
                        * (2*nws_pkg::LIMIT_W)'(dist_limit_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         pose_x_ff        <= '0;
         pose_y_ff        <= '0;
         pose_heading_ff  <= '0;
         heading_limit_ff <= nws_pkg::HEADING_LIMIT_RESET;
         lim_sq_ff        <= nws_pkg::LIM_SQ_RESET;
      end else if (csr_wr_en) begin
         unique case (nws_pkg::nws_csr_idx_type'(csr_index))
            nws_pkg::CSR_POSE_X:        pose_x_ff <= csr_wdata;
            nws_pkg::CSR_POSE_Y:        pose_y_ff <= csr_wdata;
            nws_pkg::CSR_POSE_HEADING:  pose_heading_ff <= csr_wdata[nws_pkg::ANGLE_W-1:0];
            nws_pkg::CSR_DIST_LIMIT:    lim_sq_ff <= nws_pkg::DIST_W'(lim_prod);
            nws_pkg::CSR_HEADING_LIMIT: heading_limit_ff <= csr_wdata[nws_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // elastic pipeline: a stage takes new data when empty or moving on
   assign rdy3      = !v3_ff || trk_ready;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;
   assign accept    = req_valid && rdy1;

   // count waypoints, saturate past capacity, restart after the closing one
   assign in_range = count_ff < CNT_MAX;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (accept) begin
         if (req_last_point) begin
            count_ff <= '0;
         end else if (count_ff <= CNT_MAX) begin
            count_ff <= count_ff + CNT_W'(1);
         end
      end
   end

   // offsets, their magnitudes and the wrapped yaw gate
   assign dx    = {req_wp_x[nws_pkg::COORD_W-1], req_wp_x}
                - $signed({pose_x_ff[nws_pkg::COORD_W-1], pose_x_ff});
   assign dy    = {req_wp_y[nws_pkg::COORD_W-1], req_wp_y}
                - $signed({pose_y_ff[nws_pkg::COORD_W-1], pose_y_ff});
   assign ndx   = '0 - dx;
   assign ndy   = '0 - dy;
   assign hdiff = req_wp_heading - pose_heading_ff;
   assign hmag  = hdiff[nws_pkg::ANGLE_W-1] ? ((nws_pkg::ANGLE_W+1)'(1) << nws_pkg::ANGLE_W)
                                                - {1'b0, hdiff}
                                              : {1'b0, hdiff};
   assign hd_ok = hmag <= {1'b0, heading_limit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (rdy1) begin
         v1_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         adx_ff   <= dx[nws_pkg::COORD_W] ? ndx[nws_pkg::COORD_W-1:0] : dx[nws_pkg::COORD_W-1:0];
         ady_ff   <= dy[nws_pkg::COORD_W] ? ndy[nws_pkg::COORD_W-1:0] : dy[nws_pkg::COORD_W-1:0];
         hd_ok_ff <= hd_ok;
         rng1_ff  <= in_range;
         last1_ff <= req_last_point;
         pos1_ff  <= count_ff[IDX_W-1:0];
      end
   end

   // square each offset magnitude
   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v1_ff && rdy2) begin
         sx_ff    <= nws_pkg::DIST_W'(adx_ff) * nws_pkg::DIST_W'(adx_ff);
         sy_ff    <= nws_pkg::DIST_W'(ady_ff) * nws_pkg::DIST_W'(ady_ff);
         ok2_ff   <= hd_ok_ff && rng1_ff;
         rng2_ff  <= rng1_ff;
         last2_ff <= last1_ff;
         pos2_ff  <= pos1_ff;
      end
   end

   // saturating sum and distance gate
   assign dsum = {1'b0, sx_ff} + {1'b0, sy_ff};
   assign ds   = dsum[nws_pkg::DIST_W] ? '1 : dsum[nws_pkg::DIST_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         ds_ff         <= ds;
         cand3_ff.qual <= ok2_ff && (ds <= lim_sq_ff);
         cand3_ff.over <= !rng2_ff;
         cand3_ff.last <= last2_ff;
         pos3_ff       <= pos2_ff;
      end
   end

   // running minimum and result register
   nws_tracker #(
      .IDX_W (IDX_W)
   ) u_tracker (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (v3_ff),
      .in_ready       (trk_ready),
      .in_cand        (cand3_ff),
      .in_dist        (ds_ff),
      .in_pos         (pos3_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_found      (rsp_found),
      .rsp_best_index (rsp_best_index),
      .rsp_overflow   (rsp_overflow)
   );

`include "nearest_waypoint_search_top_defines.svh"

   `NWS_ASSERT_IMP(a_count_bound, 1'b1, count_ff <= CNT_MAX + CNT_W'(1), "waypoint count past saturation")
   `NWS_ASSERT_NEXT(a_count_restart, accept && req_last_point, count_ff == '0, "count not restarted after closing waypoint")
   `NWS_ASSERT_IMP(a_ready_when_empty, !v1_ff, req_ready, "input stalled with empty first stage")

endmodule
